// ===== rtl/core/fol_pkg.sv =====
// ----------------------------------------------------------------------------
// fol_pkg
// Shared types and constants for the frequency-ordered list core.
// ----------------------------------------------------------------------------
package fol_pkg;

  localparam int ENTRIES_DEF     = 64;
  localparam int VALUE_WIDTH_DEF = 16;
  localparam int COUNT_WIDTH_DEF = 16;

  localparam int IN_VALUE_W = 16;
  localparam int STATUS_W   = 2;
  localparam int POS_W      = 7;

  typedef enum logic {
    REQ_APPEND = 1'b0,
    REQ_ACCESS = 1'b1
  } fol_req_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE      = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_FULL      = 2'd2
  } fol_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FIND,
    ST_SEL,
    ST_MOVE
  } fol_state_t;

  typedef struct packed {
    logic                  req_type;
    logic [IN_VALUE_W-1:0] value;
  } fol_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    pos_before;
    logic [POS_W-1:0]    pos_after;
  } fol_out_t;

  typedef struct packed {
    logic load_new;
    logic move;
  } fol_cell_ctrl_t;

endpackage

// ===== rtl/core/fol_cell.sv =====
// ----------------------------------------------------------------------------
// fol_cell
// One list slot: value and count, local match and shift-down from neighbour.
// ----------------------------------------------------------------------------
module fol_cell #(
  parameter int INDEX       = 0,
  parameter int VALUE_WIDTH = fol_pkg::VALUE_WIDTH_DEF,
  parameter int COUNT_WIDTH = fol_pkg::COUNT_WIDTH_DEF,
  parameter int IDX_W       = 6,
  parameter int TOT_W       = 7
) (
  input  logic                    clk,
  input  fol_pkg::fol_cell_ctrl_t ctrl,
  input  logic [VALUE_WIDTH-1:0]  key,
  input  logic [COUNT_WIDTH-1:0]  cnt_new,
  input  logic [TOT_W-1:0]        total,
  input  logic [IDX_W-1:0]        found_idx,
  input  logic                    sel,
  input  logic [VALUE_WIDTH-1:0]  prev_value,
  input  logic [COUNT_WIDTH-1:0]  prev_count,
  input  logic                    prev_lt,
  output logic [VALUE_WIDTH-1:0]  value,
  output logic [COUNT_WIDTH-1:0]  count,
  output logic                    match,
  output logic                    lt,
  output logic                    head,
  output logic [COUNT_WIDTH-1:0]  sel_count
);

  logic [VALUE_WIDTH-1:0] value_r;
  logic [COUNT_WIDTH-1:0] count_r;
  logic                   valid;
  logic                   is_found;
  logic                   shift_en;

  assign valid     = TOT_W'(INDEX) < total;
  assign match     = valid && (value_r == key);
  assign is_found  = IDX_W'(INDEX) == found_idx;
  assign lt        = (IDX_W'(INDEX) < found_idx) && (count_r < cnt_new);
  assign shift_en  = lt || is_found;
  assign head      = shift_en && !prev_lt;
  assign sel_count = sel ? count_r : '0;
  assign value     = value_r;
  assign count     = count_r;

  always_ff @(posedge clk) begin
    if (ctrl.load_new && (total == TOT_W'(INDEX))) begin
      value_r <= key;
      count_r <= '0;
    end else if (ctrl.move && shift_en) begin
      if (prev_lt) begin
        value_r <= prev_value;
        count_r <= prev_count;
      end else begin
        value_r <= key;
        count_r <= cnt_new;
      end
    end
  end

endmodule

// ===== rtl/core/frequency_ordered_list_core.sv =====
// ----------------------------------------------------------------------------
// frequency_ordered_list_core
// Self-organising list with access counts, kept in a row of slot cells.
// ----------------------------------------------------------------------------
//  channel  ports                      handshake
//  input    start, busy, in_word       taken when start && !busy
//  result   out_strobe, out_word       one-cycle strobe per word, no back-pressure
//
//  Append: busy stays low. Access hit: accept, compare and lowest-match
//  isolate, count select, shift of the cell row. Access miss: the shift is
//  skipped.
//  Result appears the cycle after the item finishes; a new word may be taken
//  in that same cycle. Reset clears the entry total and control only.
// ----------------------------------------------------------------------------
module frequency_ordered_list_core #(
  parameter int ENTRIES     = fol_pkg::ENTRIES_DEF,
  parameter int VALUE_WIDTH = fol_pkg::VALUE_WIDTH_DEF,
  parameter int COUNT_WIDTH = fol_pkg::COUNT_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  fol_pkg::fol_in_t in_word,
  output logic             out_strobe,
  output fol_pkg::fol_out_t out_word
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int TOT_W = $clog2(ENTRIES + 1);

  fol_pkg::fol_state_t    state_r, state_nxt;
  logic [TOT_W-1:0]       total_r, total_nxt;
  logic [VALUE_WIDTH-1:0] key_r;
  logic [ENTRIES-1:0]     onehot_r;
  logic [IDX_W-1:0]       found_idx_r, found_idx_nxt;
  logic [COUNT_WIDTH-1:0] cnt_new_r, cnt_new_nxt;
  logic                   out_strobe_r, out_strobe_nxt;
  fol_pkg::fol_out_t      out_word_r, out_word_nxt;

  fol_pkg::fol_cell_ctrl_t ctrl;
  logic [VALUE_WIDTH-1:0]  key;
  logic [VALUE_WIDTH-1:0]  in_value;
  logic                    accept;
  logic                    full;

  logic [ENTRIES-1:0]     match_vec;
  logic [ENTRIES-1:0]     lt_vec;
  logic [ENTRIES-1:0]     head_vec;
  logic [ENTRIES-1:0]     lowest;
  logic [VALUE_WIDTH-1:0] value_arr [ENTRIES];
  logic [COUNT_WIDTH-1:0] count_arr [ENTRIES];
  logic [COUNT_WIDTH-1:0] sel_count_arr [ENTRIES];

  logic [IDX_W-1:0]       sel_idx;
  logic [COUNT_WIDTH-1:0] sel_count;
  logic [IDX_W-1:0]       head_idx;
  logic [IDX_W:0]         before_full;
  logic [IDX_W:0]         after_full;
  logic [TOT_W-1:0]       total_plus;

  assign in_value   = VALUE_WIDTH'(in_word.value);
  assign accept     = start && (state_r == fol_pkg::ST_IDLE);
  assign busy       = state_r != fol_pkg::ST_IDLE;
  assign full       = total_r == TOT_W'(ENTRIES);
  assign key        = (state_r == fol_pkg::ST_IDLE) ? in_value : key_r;
  assign total_plus = total_r + 1'b1;
  assign lowest     = match_vec & (~match_vec + ENTRIES'(1));

  genvar g;
  generate
    for (g = 0; g < ENTRIES; g++) begin : g_cell
      logic [VALUE_WIDTH-1:0] pv;
      logic [COUNT_WIDTH-1:0] pc;
      logic                   pl;
      if (g == 0) begin : g_first
        assign pv = '0;
        assign pc = '0;
        assign pl = 1'b0;
      end else begin : g_rest
        assign pv = value_arr[g-1];
        assign pc = count_arr[g-1];
        assign pl = lt_vec[g-1];
      end
      fol_cell #(
        .INDEX      (g),
        .VALUE_WIDTH(VALUE_WIDTH),
        .COUNT_WIDTH(COUNT_WIDTH),
        .IDX_W      (IDX_W),
        .TOT_W      (TOT_W)
      ) u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .key       (key),
        .cnt_new   (cnt_new_r),
        .total     (total_r),
        .found_idx (found_idx_r),
        .sel       (onehot_r[g]),
        .prev_value(pv),
        .prev_count(pc),
        .prev_lt   (pl),
        .value     (value_arr[g]),
        .count     (count_arr[g]),
        .match     (match_vec[g]),
        .lt        (lt_vec[g]),
        .head      (head_vec[g]),
        .sel_count (sel_count_arr[g])
      );
    end
  endgenerate

  always_comb begin
    sel_idx   = '0;
    sel_count = '0;
    head_idx  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (onehot_r[i]) begin
        sel_idx = sel_idx | IDX_W'(i);
      end
      if (head_vec[i]) begin
        head_idx = head_idx | IDX_W'(i);
      end
      sel_count = sel_count | sel_count_arr[i];
    end
  end

  assign before_full = {1'b0, found_idx_r} + 1'b1;
  assign after_full  = {1'b0, head_idx} + 1'b1;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fol_pkg::ST_IDLE: begin
        if (accept && (in_word.req_type == fol_pkg::REQ_ACCESS)) begin
          state_nxt = fol_pkg::ST_FIND;
        end
      end
      fol_pkg::ST_FIND: state_nxt = fol_pkg::ST_SEL;
      fol_pkg::ST_SEL: begin
        if (onehot_r == '0) begin
          state_nxt = fol_pkg::ST_IDLE;
        end else begin
          state_nxt = fol_pkg::ST_MOVE;
        end
      end
      fol_pkg::ST_MOVE: state_nxt = fol_pkg::ST_IDLE;
      default:          state_nxt = fol_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath controls
  always_comb begin
    ctrl           = '0;
    total_nxt      = total_r;
    found_idx_nxt  = found_idx_r;
    cnt_new_nxt    = cnt_new_r;
    out_strobe_nxt = 1'b0;
    out_word_nxt   = out_word_r;
    unique case (state_r)
      fol_pkg::ST_IDLE: begin
        if (accept && (in_word.req_type == fol_pkg::REQ_APPEND)) begin
          out_strobe_nxt = 1'b1;
          if (full) begin
            out_word_nxt.status     = fol_pkg::STATUS_FULL;
            out_word_nxt.pos_before = '0;
            out_word_nxt.pos_after  = '0;
          end else begin
            ctrl.load_new           = 1'b1;
            total_nxt               = total_plus;
            out_word_nxt.status     = fol_pkg::STATUS_DONE;
            out_word_nxt.pos_before = '0;
            out_word_nxt.pos_after  = fol_pkg::POS_W'(total_plus);
          end
        end
      end
      fol_pkg::ST_FIND: begin
      end
      fol_pkg::ST_SEL: begin
        if (onehot_r == '0) begin
          out_strobe_nxt          = 1'b1;
          out_word_nxt.status     = fol_pkg::STATUS_NOT_FOUND;
          out_word_nxt.pos_before = '0;
          out_word_nxt.pos_after  = '0;
        end else begin
          found_idx_nxt = sel_idx;
          cnt_new_nxt   = (sel_count == '1) ? sel_count : sel_count + 1'b1;
        end
      end
      fol_pkg::ST_MOVE: begin
        ctrl.move               = 1'b1;
        out_strobe_nxt          = 1'b1;
        out_word_nxt.status     = fol_pkg::STATUS_DONE;
        out_word_nxt.pos_before = fol_pkg::POS_W'(before_full);
        out_word_nxt.pos_after  = fol_pkg::POS_W'(after_full);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= fol_pkg::ST_IDLE;
      total_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      total_r      <= total_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key_r <= in_value;
    end
    if (state_r == fol_pkg::ST_FIND) begin
      onehot_r <= lowest;
    end
    found_idx_r <= found_idx_nxt;
    cnt_new_r   <= cnt_new_nxt;
    out_word_r  <= out_word_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

endmodule
